>>> sv/bse_pkg.sv
// Package: shared types, widths and codes of the battery status estimator.
`default_nettype none

package bse_pkg;

  // Data widths
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIV_W     = 38;  // dividend and quotient width: 60 * 32-bit amount
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_UNIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESIGN_VOLT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DESIGN_CAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_CAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_OVR    = 3'd4;

  // Mode codes
  localparam logic [1:0] MODE_FULL      = 2'd0;
  localparam logic [1:0] MODE_DISCHARGE = 2'd1;
  localparam logic [1:0] MODE_CHARGE    = 2'd2;
  localparam logic [1:0] MODE_FAILURE   = 2'd3;

  // Constants
  localparam logic [WORD_W-1:0] RATE_MASK      = 32'h0000_0FFF;
  localparam logic [WORD_W-1:0] UNKNOWN_TIME   = 32'h0000_FFFF;
  localparam logic [WORD_W-1:0] RAW_CAP_LIMIT  = 32'd10000;
  localparam logic [WORD_W-1:0] MV_PER_V       = 32'd1000;
  localparam logic [WORD_W-1:0] CYCLE_DIVISOR  = 32'd7;

  // Input item
  typedef struct packed {
    logic [WORD_W-1:0] battery_state;
    logic [WORD_W-1:0] present_rate;
    logic [WORD_W-1:0] remaining_capacity;
  } bse_in_t;

  // Result item
  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] amperage;
    logic signed [WORD_W-1:0] instant_amperage;
    logic [WORD_W-1:0]        avg_time_to_empty;
    logic [WORD_W-1:0]        avg_time_to_full;
    logic [WORD_W-1:0]        inst_time_to_empty;
    logic [WORD_W-1:0]        inst_time_to_full;
    logic [WORD_W-1:0]        current_capacity;
    logic                     quick_poll;
    logic [WORD_W-1:0]        cycle_count;
    logic                     capacity_error;
  } bse_out_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_resp_t;

endpackage

`default_nettype wire

>>> sv/bse_ifs.sv
// Interfaces: input, result and configuration channels of the estimator.
`default_nettype none

interface bse_in_if import bse_pkg::*; ();
  logic    valid;
  logic    ready;
  bse_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bse_out_if import bse_pkg::*; ();
  logic     valid;
  logic     ready;
  bse_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bse_cfg_if import bse_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> sv/bse_div.sv
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none

module bse_div import bse_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire div_req_t  req_i,
  output div_resp_t      resp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [WORD_W-1:0]    rem_q, dvs_q;
  logic [DIV_W-1:0]     quo_q;

  logic [WORD_W:0] trial, diff;
  logic            fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign resp_o.busy     = busy_q;
  assign resp_o.done     = done_q;
  assign resp_o.quotient = quo_q;

endmodule

`default_nettype wire

>>> sv/battery_status_estimator.sv
// Top level: battery status estimator with sequencer around one shared divider.
`default_nettype none

// Each status item runs ten divisions between acceptance and result (volts from
// millivolts, design, full, remaining capacity and rate scaling, four time
// estimates and the cycle count), one after the other on a single 38-step
// restoring divider. The input channel is ready only while no item is in work;
// a finished result waits in an output register, so a new item can be taken
// before the result is read.
// Configuration writes are taken at any time and must only be made while the
// block is idle.
module battery_status_estimator import bse_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bse_cfg_if.sink    cfg_i,
  bse_in_if.sink     in_i,
  bse_out_if.source  out_o
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // Division steps
  localparam logic [3:0] OP_VOLT = 4'd0;
  localparam logic [3:0] OP_DES  = 4'd1;
  localparam logic [3:0] OP_FULL = 4'd2;
  localparam logic [3:0] OP_CAP  = 4'd3;
  localparam logic [3:0] OP_RATE = 4'd4;
  localparam logic [3:0] OP_ATE  = 4'd5;
  localparam logic [3:0] OP_ITE  = 4'd6;
  localparam logic [3:0] OP_ATF  = 4'd7;
  localparam logic [3:0] OP_ITF  = 4'd8;
  localparam logic [3:0] OP_CYC  = 4'd9;

  // Configuration registers
  logic [WORD_W-1:0] cfg_unit_q, cfg_volt_q, cfg_dcap_q, cfg_fcap_q;
  logic              cfg_povr_q;

  // Control and state
  logic [1:0]        state_q, state_d;
  logic [3:0]        op_q, op_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] avg_q, last_q;
  logic              qp_q;

  // Per-item datapath registers
  bse_in_t           item_q;
  logic [WORD_W-1:0] volt_div_q, design_q, full_q, cap_q, rate_q;
  logic [WORD_W-1:0] ate_q, ite_q, atf_q, itf_q, cyc_q;
  bse_out_t          out_q, out_d;

  // Divider link
  div_req_t  div_req;
  div_resp_t div_resp;

  logic in_acc, cfg_acc, out_load;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_unit_q <= '0;
      cfg_volt_q <= '0;
      cfg_dcap_q <= '0;
      cfg_fcap_q <= '0;
      cfg_povr_q <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        CFG_POWER_UNIT:  cfg_unit_q <= cfg_i.wdata;
        CFG_DESIGN_VOLT: cfg_volt_q <= cfg_i.wdata;
        CFG_DESIGN_CAP:  cfg_dcap_q <= cfg_i.wdata;
        CFG_FULL_CAP:    cfg_fcap_q <= cfg_i.wdata;
        CFG_POLL_OVR:    cfg_povr_q <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // Unit divisor selection
  logic [WORD_W-1:0] unit_base, unit;
  always_comb begin
    unit_base = (cfg_unit_q != '0) ? cfg_unit_q :
                (volt_div_q != '0) ? volt_div_q : WORD_W'(1);
    unit = (unit_base > WORD_W'(1) && cfg_dcap_q < RAW_CAP_LIMIT) ? WORD_W'(1) : unit_base;
  end

  // Time dividends: 60 * amount as (x << 6) - (x << 2)
  logic [WORD_W-1:0] toward, cap_diff;
  logic [DIV_W-1:0]  cap60, tow60;
  always_comb begin
    toward   = (full_q > cap_q) ? (full_q - cap_q) : '0;
    cap_diff = (design_q > full_q) ? (design_q - full_q) : (full_q - design_q);
    cap60    = ({6'd0, cap_q} << 6) - ({6'd0, cap_q} << 2);
    tow60    = ({6'd0, toward} << 6) - ({6'd0, toward} << 2);
  end

  // Divider operand selection
  always_comb begin
    div_req.start = (state_q == S_LOAD);
    case (op_q)
      OP_VOLT: begin div_req.dividend = {6'd0, cfg_volt_q};   div_req.divisor = MV_PER_V;      end
      OP_DES:  begin div_req.dividend = {6'd0, cfg_dcap_q};   div_req.divisor = unit;          end
      OP_FULL: begin div_req.dividend = {6'd0, cfg_fcap_q};   div_req.divisor = unit;          end
      OP_CAP:  begin
        div_req.dividend = {6'd0, item_q.remaining_capacity};
        div_req.divisor  = unit;
      end
      OP_RATE: begin div_req.dividend = {6'd0, item_q.present_rate}; div_req.divisor = unit; end
      OP_ATE:  begin div_req.dividend = cap60;                div_req.divisor = avg_q;         end
      OP_ITE:  begin div_req.dividend = cap60;                div_req.divisor = rate_q;        end
      OP_ATF:  begin div_req.dividend = tow60;                div_req.divisor = avg_q;         end
      OP_ITF:  begin div_req.dividend = tow60;                div_req.divisor = rate_q;        end
      OP_CYC:  begin div_req.dividend = {6'd0, cap_diff};     div_req.divisor = CYCLE_DIVISOR; end
      default: begin div_req.dividend = '0;                   div_req.divisor = WORD_W'(1);    end
    endcase
  end

  bse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  // Quotient post-processing
  logic [WORD_W-1:0] q32, time_res, rate_new, avg_mid, avg_new;
  logic [WORD_W:0]   avg_sum;
  always_comb begin
    q32      = div_resp.quotient[WORD_W-1:0];
    time_res = (div_req.divisor == '0) ? UNKNOWN_TIME :
               (div_resp.quotient[DIV_W-1:WORD_W] != '0) ? '1 : q32;
    rate_new = (q32 == '0) ? {1'b0, full_q[WORD_W-1:1]} : (q32 & RATE_MASK);
    avg_sum  = {1'b0, avg_q} + {1'b0, rate_new};
    avg_mid  = (avg_q != '0) ? avg_sum[WORD_W:1] : rate_new;
    avg_new  = (item_q.battery_state != last_q) ? '0 : avg_mid;
  end

  logic step_done;
  assign step_done = (state_q == S_WAIT) && div_resp.done;

  // Sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LOAD;
          op_d    = OP_VOLT;
        end
      end
      S_LOAD: state_d = S_WAIT;
      S_WAIT: begin
        if (div_resp.done) begin
          if (op_q == OP_CYC) begin
            state_d = S_DONE;
          end else begin
            state_d = S_LOAD;
            op_d    = op_q + 4'd1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  // Result assembly
  logic [WORD_W-1:0] cap_eff;
  logic [36:0]       cap20;
  logic              ext_power, qp_next;
  always_comb begin
    out_d = '0;
    case (item_q.battery_state[1:0])
      2'b11: begin
        out_d.mode = MODE_FAILURE;
        cap_eff    = cap_q;
        ext_power  = 1'b1;
      end
      2'b01: begin
        out_d.mode               = MODE_DISCHARGE;
        out_d.amperage           = WORD_W'(0) - avg_q;
        out_d.instant_amperage   = WORD_W'(0) - rate_q;
        out_d.avg_time_to_empty  = ate_q;
        out_d.inst_time_to_empty = ite_q;
        out_d.avg_time_to_full   = UNKNOWN_TIME;
        out_d.inst_time_to_full  = UNKNOWN_TIME;
        cap_eff                  = cap_q;
        ext_power                = 1'b0;
      end
      2'b10: begin
        out_d.mode               = MODE_CHARGE;
        out_d.amperage           = avg_q;
        out_d.instant_amperage   = rate_q;
        out_d.avg_time_to_full   = atf_q;
        out_d.inst_time_to_full  = itf_q;
        out_d.avg_time_to_empty  = UNKNOWN_TIME;
        out_d.inst_time_to_empty = UNKNOWN_TIME;
        cap_eff                  = cap_q;
        ext_power                = 1'b1;
      end
      default: begin
        out_d.mode               = MODE_FULL;
        out_d.avg_time_to_empty  = UNKNOWN_TIME;
        out_d.inst_time_to_empty = UNKNOWN_TIME;
        out_d.avg_time_to_full   = UNKNOWN_TIME;
        out_d.inst_time_to_full  = UNKNOWN_TIME;
        cap_eff                  = full_q;
        ext_power                = 1'b1;
      end
    endcase
    // below five percent: 100 * cap / full < 5 exactly when 20 * cap < full
    cap20   = ({5'd0, cap_eff} << 4) + ({5'd0, cap_eff} << 2);
    qp_next = (!cfg_povr_q && full_q != '0) ? ((cap20 < {5'd0, full_q}) && ext_power) : qp_q;
    out_d.current_capacity = cap_eff;
    out_d.quick_poll       = qp_next;
    out_d.cycle_count      = cyc_q;
    out_d.capacity_error   = (design_q == '0) || (full_q == '0);
  end

  // Control and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_VOLT;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      last_q      <= '0;
      qp_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      if (step_done && op_q == OP_RATE) begin
        avg_q  <= avg_new;
        last_q <= item_q.battery_state;
      end
      if (out_load) begin
        qp_q <= qp_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i.data;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    if (step_done) begin
      case (op_q)
        OP_VOLT: volt_div_q <= q32;
        OP_DES:  design_q   <= q32;
        OP_FULL: full_q     <= q32;
        OP_CAP:  cap_q      <= q32;
        OP_RATE: rate_q     <= rate_new;
        OP_ATE:  ate_q      <= time_res;
        OP_ITE:  ite_q      <= time_res;
        OP_ATF:  atf_q      <= time_res;
        OP_ITF:  itf_q      <= time_res;
        OP_CYC:  cyc_q      <= q32;
        default: ;
      endcase
    end
  end

  // Checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_resp.busy)
    else $error("divider started while busy");

  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_resp.done |-> (state_q == S_WAIT))
    else $error("divider result arrived outside wait state");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_LOAD) && (op_q == OP_VOLT))
    else $error("accepted item did not start the division sequence");

  a_load_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !out_load)
    else $error("result overwritten while waiting");

endmodule

`default_nettype wire

>>> tb/bse_status_checker.sv
// Checker: predicts each battery status result and compares it with the block's output.
`timescale 1ns / 100ps

module bse_status_checker import bse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  bse_in_t              in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  bse_out_t             out_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);

  localparam logic [63:0] MINUTES_PER_HOUR = 64'd60;
  localparam logic [63:0] PERCENT_SCALE    = 64'd100;
  localparam logic [63:0] QUICK_POLL_PCT   = 64'd5;
  localparam int unsigned REPORT_LIMIT     = 10;

  // Shadow of the configuration registers
  logic [WORD_W-1:0] power_unit_q  = '0;
  logic [WORD_W-1:0] design_volt_q = '0;
  logic [WORD_W-1:0] design_cap_q  = '0;
  logic [WORD_W-1:0] full_cap_q    = '0;
  logic              poll_ovr_q    = 1'b0;

  // Shadow of the running state
  logic [WORD_W-1:0] avg_rate_q    = '0;
  logic [WORD_W-1:0] last_state_q  = '0;
  logic              quick_poll_q  = 1'b0;

  bse_out_t    expected_status_q[$];
  bse_out_t    oldest_status;
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;

  // Minutes until amount is used up at rate; unknown for a zero rate
  function automatic logic [WORD_W-1:0] minutes_left(logic [WORD_W-1:0] amount,
                                                     logic [WORD_W-1:0] rate);
    logic [63:0] quot;
    if (rate == '0) return UNKNOWN_TIME;
    quot = (MINUTES_PER_HOUR * {32'd0, amount}) / {32'd0, rate};
    return (quot > 64'h0000_0000_FFFF_FFFF) ? '1 : quot[WORD_W-1:0];
  endfunction

  // Work out the result of one status item and advance the running state
  function automatic bse_out_t predict_status(bse_in_t item);
    logic [WORD_W-1:0] unit, des_cap, full, cap, rate, toward;
    logic [WORD_W:0]   rate_sum;
    logic [63:0]       pct;
    logic              ext_power;
    bse_out_t          res;

    unit = power_unit_q;
    if (unit == '0) unit = design_volt_q / MV_PER_V;
    if (unit == '0) unit = 1;
    if (unit > 1 && design_cap_q < RAW_CAP_LIMIT) unit = 1;

    des_cap = design_cap_q / unit;
    full    = full_cap_q / unit;
    cap     = item.remaining_capacity / unit;
    rate    = item.present_rate / unit;
    if (rate == '0) rate = full >> 1;
    else rate = rate & RATE_MASK;

    // Average the rate, then drop it when the state word moves
    if (avg_rate_q != '0) begin
      rate_sum   = {1'b0, avg_rate_q} + {1'b0, rate};
      avg_rate_q = rate_sum[WORD_W:1];
    end else begin
      avg_rate_q = rate;
    end
    if (item.battery_state != last_state_q) begin
      last_state_q = item.battery_state;
      avg_rate_q   = '0;
    end

    res = '0;
    // The two low state bits map straight onto the mode code
    case (item.battery_state[1:0])
      MODE_FAILURE: begin
        res.mode = MODE_FAILURE;
        ext_power = 1'b1;
      end
      MODE_DISCHARGE: begin
        res.mode               = MODE_DISCHARGE;
        ext_power              = 1'b0;
        res.amperage           = '0 - avg_rate_q;
        res.instant_amperage   = '0 - rate;
        res.avg_time_to_empty  = minutes_left(cap, avg_rate_q);
        res.inst_time_to_empty = minutes_left(cap, rate);
        res.avg_time_to_full   = UNKNOWN_TIME;
        res.inst_time_to_full  = UNKNOWN_TIME;
      end
      MODE_CHARGE: begin
        res.mode               = MODE_CHARGE;
        ext_power              = 1'b1;
        res.amperage           = avg_rate_q;
        res.instant_amperage   = rate;
        toward                 = (full > cap) ? full - cap : '0;
        res.avg_time_to_full   = minutes_left(toward, avg_rate_q);
        res.inst_time_to_full  = minutes_left(toward, rate);
        res.avg_time_to_empty  = UNKNOWN_TIME;
        res.inst_time_to_empty = UNKNOWN_TIME;
      end
      default: begin
        res.mode               = MODE_FULL;
        ext_power              = 1'b1;
        res.avg_time_to_empty  = UNKNOWN_TIME;
        res.avg_time_to_full   = UNKNOWN_TIME;
        res.inst_time_to_empty = UNKNOWN_TIME;
        res.inst_time_to_full  = UNKNOWN_TIME;
        cap                    = full;
      end
    endcase

    // Quick poll follows the charge level unless frozen or full is unknown
    if (!poll_ovr_q && full != '0) begin
      pct          = ({32'd0, cap} * PERCENT_SCALE) / {32'd0, full};
      quick_poll_q = (pct < QUICK_POLL_PCT) && ext_power;
    end

    res.current_capacity = cap;
    res.quick_poll       = quick_poll_q;
    res.cycle_count      = ((des_cap > full) ? des_cap - full : full - des_cap) / CYCLE_DIVISOR;
    res.capacity_error   = (des_cap == '0 || full == '0);
    return res;
  endfunction

  task automatic note_mismatch(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: result %0d, %s: expected %h, got %h", $realtime, results_seen, field,
               want, got);
  endtask

  task automatic compare_status(bse_out_t want, bse_out_t got);
    if (got.mode !== want.mode) note_mismatch("mode", want.mode, got.mode);
    if (got.amperage !== want.amperage)
      note_mismatch("amperage", want.amperage, got.amperage);
    if (got.instant_amperage !== want.instant_amperage)
      note_mismatch("instant_amperage", want.instant_amperage, got.instant_amperage);
    if (got.avg_time_to_empty !== want.avg_time_to_empty)
      note_mismatch("avg_time_to_empty", want.avg_time_to_empty, got.avg_time_to_empty);
    if (got.avg_time_to_full !== want.avg_time_to_full)
      note_mismatch("avg_time_to_full", want.avg_time_to_full, got.avg_time_to_full);
    if (got.inst_time_to_empty !== want.inst_time_to_empty)
      note_mismatch("inst_time_to_empty", want.inst_time_to_empty, got.inst_time_to_empty);
    if (got.inst_time_to_full !== want.inst_time_to_full)
      note_mismatch("inst_time_to_full", want.inst_time_to_full, got.inst_time_to_full);
    if (got.current_capacity !== want.current_capacity)
      note_mismatch("current_capacity", want.current_capacity, got.current_capacity);
    if (got.quick_poll !== want.quick_poll)
      note_mismatch("quick_poll", want.quick_poll, got.quick_poll);
    if (got.cycle_count !== want.cycle_count)
      note_mismatch("cycle_count", want.cycle_count, got.cycle_count);
    if (got.capacity_error !== want.capacity_error)
      note_mismatch("capacity_error", want.capacity_error, got.capacity_error);
  endtask

  // Check results first, then take register writes and new items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_unit_q  <= '0;
      design_volt_q <= '0;
      design_cap_q  <= '0;
      full_cap_q    <= '0;
      poll_ovr_q    <= 1'b0;
      avg_rate_q    <= '0;
      last_state_q  <= '0;
      quick_poll_q  <= 1'b0;
      expected_status_q.delete();
      pending_o     <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (expected_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result %0d arrived with no item pending", $realtime, results_seen);
        end else begin
          oldest_status = expected_status_q.pop_front();
          compare_status(oldest_status, out_data_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_POWER_UNIT:  power_unit_q  = cfg_wdata_i;
          CFG_DESIGN_VOLT: design_volt_q = cfg_wdata_i;
          CFG_DESIGN_CAP:  design_cap_q  = cfg_wdata_i;
          CFG_FULL_CAP:    full_cap_q    = cfg_wdata_i;
          CFG_POLL_OVR:    poll_ovr_q    = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_status_q.push_back(predict_status(in_data_i));
      pending_o        <= expected_status_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> tb/tb_battery_status_estimator.sv
// Testbench top: drives status items and register writes into the estimator, gives the verdict.
`timescale 1ns / 100ps

module tb_battery_status_estimator;
  import bse_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_POLL_OVR + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST     = '1;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned PHASE_ITEMS     = 148;
  localparam int unsigned HOLD_OFF_AT     = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  localparam int unsigned SETTLE_CYCLES   = 500;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bse_cfg_if cfg_ch ();
  bse_in_if  in_ch ();
  bse_out_if out_ch ();

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned items_sent    = 0;
  int unsigned idle_cycles   = 0;
  bit          calm          = 1'b0;
  bit          hold_off_done = 1'b0;

  // Rough shape of the current setting, used only to aim the stimulus
  logic [WORD_W-1:0] stim_full_raw = '0;
  logic [WORD_W-1:0] stim_scale    = 1;

  battery_status_estimator u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  bse_status_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_ch.valid),
    .cfg_ready_i      (cfg_ch.ready),
    .cfg_index_i      (cfg_ch.index),
    .cfg_wdata_i      (cfg_ch.wdata),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .in_data_i        (in_ch.data),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_data_i       (out_ch.data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 450);
    return $urandom_range(451, 800);
  endfunction

  // Register values weighted toward zero, one, the capacity boundary and all ones
  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 25) return 1;
    if (roll < 50) return $urandom_range(2, 64);
    if (roll < 65) return $urandom_range(RAW_CAP_LIMIT - 10, RAW_CAP_LIMIT + 10);
    if (roll < 90) return $urandom();
    return '1;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write every register, plus one index the block must ignore
  task automatic set_config(logic [WORD_W-1:0] unit_word, logic [WORD_W-1:0] volt,
                            logic [WORD_W-1:0] dcap, logic [WORD_W-1:0] fcap,
                            logic override);
    write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_IDX_LAST)), $urandom());
    write_reg(CFG_POWER_UNIT, unit_word);
    write_reg(CFG_DESIGN_VOLT, volt);
    write_reg(CFG_DESIGN_CAP, dcap);
    write_reg(CFG_FULL_CAP, fcap);
    write_reg(CFG_POLL_OVR, {31'($urandom()), override});
    cfg_ch.valid  <= 1'b0;
    stim_full_raw  = fcap;
    if (unit_word != '0) stim_scale = unit_word;
    else if (volt / MV_PER_V != '0) stim_scale = volt / MV_PER_V;
    else stim_scale = 1;
  endtask

  task automatic send_status(logic [WORD_W-1:0] st, logic [WORD_W-1:0] rate,
                             logic [WORD_W-1:0] cap);
    int unsigned gap;
    bse_in_t     item;
    gap = calm ? 0 : pick_gap();
    item.battery_state      = st;
    item.present_rate       = rate;
    item.remaining_capacity = cap;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and let every expected result come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, calm phases, and one long hold-off
  initial begin : receiver
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_off_done && items_sent >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        stall = pick_gap();
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted item, result or write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL battery_status_estimator");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] run_state, st, rate, cap;
    logic [63:0]       wide;
    int unsigned       run_left, roll;

    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.wdata <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    run_state     = '0;
    run_left      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unit of one through the zero fallback, design 5000, full 4000
    set_config('0, '0, 32'd5000, 32'd4000, 1'b0);
    send_status(32'd0, 32'd0, 32'd0);                    // full mode, no state change
    send_status(32'd1, 32'd0, 32'd100);                  // zero rate takes half of full
    send_status(32'd1, 32'd300, '1);
    send_status(32'd1, 32'd1, '1);                       // time saturates
    send_status(32'd1, 32'h0000_1000, 32'd50);           // rate masks to zero
    send_status(32'd1, '1, 32'd50);
    send_status(32'd2, 32'd100, 32'd0);
    send_status(32'd2, 32'd200, 32'd5000);               // above full while charging
    send_status(32'd2, 32'd200, 32'd100);                // low charge on external power
    send_status(32'd1, 32'd200, 32'd100);
    send_status(32'd3, 32'd500, 32'd1234);               // both mode bits: failure
    send_status('1, '1, '1);
    send_status(32'hFFFF_FFFC, 32'd7, 32'd7);            // full with upper state bits
    send_status(32'd2, 32'd0, 32'd190);
    wait_idle();

    // Divisor from the voltage, full of zero, poll decision frozen
    set_config('0, 32'd12000, 32'd200000, '0, 1'b1);
    send_status(32'd2, 32'd1200, 32'd24000);
    send_status(32'd1, 32'd11, 32'd600);                 // both rates end up zero
    wait_idle();

    // Unit above one forced back to one by a small design capacity
    set_config(32'd50, '0, RAW_CAP_LIMIT - 1, 32'd20000, 1'b0);
    send_status(32'd1, 32'd4095, 32'd1000);
    wait_idle();

    // Design capacity right at the boundary keeps the unit
    set_config(32'd50, '0, RAW_CAP_LIMIT, 32'd20000, 1'b0);
    send_status(32'd2, 32'd5000, 32'd1000);
    wait_idle();

    // Everything at its maximum
    set_config('1, '1, '1, '1, 1'b0);
    send_status(32'd1, '1, '1);
    send_status(32'd2, 32'd0, 32'd0);
    wait_idle();

    set_config(32'd1, '1, '0, '1, 1'b1);
    send_status(32'd0, '0, '0);
    wait_idle();

    // Random phases: runs of a steady state word with some noise mixed in
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p % 3 == 1);
      if (p == RANDOM_PHASES - 1)
        set_config('0, '0, '0, '0, 1'b0);
      else
        set_config(pick_word(), $urandom_range(0, 1) ? pick_word() : $urandom_range(0, 60000),
                   pick_word(), pick_word(), $urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          run_state = $urandom_range(0, 3);
          if ($urandom_range(0, 9) == 0) run_state = run_state | ($urandom() & ~32'd3);
          run_left = $urandom_range(1, 16);
        end
        run_left--;
        st = ($urandom_range(0, 99) < 8) ? $urandom() : run_state;

        roll = $urandom_range(0, 99);
        if (roll < 20) rate = '0;
        else if (roll < 65) begin
          wide = {32'd0, stim_scale} * $urandom_range(1, 4095);
          rate = wide[WORD_W-1:0];
        end else if (roll < 80) rate = $urandom();
        else if (roll < 90) begin
          wide = {32'd0, stim_scale} * 4096 * $urandom_range(1, 4);
          rate = wide[WORD_W-1:0];
        end else rate = $urandom_range(0, stim_scale - 1);

        roll = $urandom_range(0, 99);
        if (roll < 10) cap = '0;
        else if (roll < 20) cap = $urandom();
        else if (roll < 60) begin
          wide = ({32'd0, stim_full_raw} * $urandom_range(0, 110)) / 100;
          cap  = wide[WORD_W-1:0];
        end else if (roll < 80) begin
          wide = ({32'd0, stim_full_raw} * $urandom_range(0, 6)) / 100;
          cap  = wide[WORD_W-1:0];
        end else cap = $urandom_range(0, stim_full_raw);

        send_status(st, rate, cap);
      end
      calm = 1'b0;
      wait_idle();
    end

    if (mismatch_count == 0 && pending == 0)
      $display("PASS battery_status_estimator");
    else
      $display("FAIL battery_status_estimator");
    $finish;
  end

endmodule
